// ===== hdl/ptsi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptsi_pkg
// Shared constants, register codes, pipeline record and helper functions for
// the padded tensor source index unit.
// ----------------------------------------------------------------------------
package ptsi_pkg;

    localparam int MAX_DIMS  = 4;
    localparam int DIM_BITS  = 16;
    localparam int IDX_W     = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int ND_W      = 3;
    localparam int MASK_W    = 4;
    localparam int JW        = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int NDC_W     = $clog2(MAX_DIMS + 1);

    // Stage offsets inside one dimension slot.
    localparam int T_POS     = IDX_W;
    localparam int T_WRAP0   = IDX_W + 1;
    localparam int T_FIX     = IDX_W + DIM_BITS + 1;
    localparam int T_MUL     = IDX_W + DIM_BITS + 2;
    localparam int T_ADD     = IDX_W + DIM_BITS + 3;
    localparam int SLOT_LEN  = IDX_W + DIM_BITS + 4;
    localparam int NUM_STAGES = MAX_DIMS * SLOT_LEN;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_DIMS     = 3'd0,
        CFG_PADDED_SIZES = 3'd1,
        CFG_PAD_BEFORE   = 3'd2,
        CFG_PAD_AFTER    = 3'd3,
        CFG_PERIODIC     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                err;
        logic [IDX_W-1:0]    q;
        logic [DIM_BITS-1:0] r;
        logic [DIM_BITS-1:0] m;
        logic [DIM_BITS-1:0] wr;
        logic                neg;
        logic [DIM_BITS-1:0] c;
        logic [IDX_W-1:0]    p;
        logic [IDX_W-1:0]    flat;
        logic [IDX_W-1:0]    stride;
    } pipe_t;

    function automatic logic [DIM_BITS-1:0] field_of(input logic [CFG_W-1:0] r,
                                                     input logic [JW-1:0] j);
        logic [DIM_BITS-1:0] f;
        int                  p;
        f = '0;
        for (int b = 0; b < DIM_BITS; b++) begin
            p = DIM_BITS * int'(j) + b;
            if (p < CFG_W) begin
                f[b] = r[p];
            end
        end
        return f;
    endfunction

    function automatic logic [CFG_W-1:0] sizes_reset();
        logic [CFG_W-1:0] v;
        v = '0;
        for (int j = 0; j < MAX_DIMS; j++) begin
            if (DIM_BITS * j < CFG_W) begin
                v[DIM_BITS*j] = 1'b1;
            end
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/padded_tensor_source_index_unit.sv =====
`default_nettype none
// Throughput: one index per cycle; every stage is a register, a stall freezes all.
// Each dimension: one index divider bit per stage, a pad offset stage, one wrap
// remainder bit per stage, then wrap fix, multiply and accumulate stages.
// Reset (rst_n, asynchronous) empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
// padded_tensor_source_index_unit
// Maps a linear index into a padded tensor to the flat index in the unpadded
// tensor, with per-dimension wrap or clamp.
// ----------------------------------------------------------------------------
module padded_tensor_source_index_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ptsi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ptsi_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [ptsi_pkg::IDX_W-1:0]     padded_index,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [ptsi_pkg::IDX_W-1:0]          source_index,
    output logic                                index_error
);
    import ptsi_pkg::*;

    logic [ND_W-1:0]   num_dims_reg;
    logic [CFG_W-1:0]  padded_sizes_reg;
    logic [CFG_W-1:0]  pad_before_reg;
    logic [CFG_W-1:0]  pad_after_reg;
    logic [MASK_W-1:0] periodic_mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg      <= ND_W'(1);
            padded_sizes_reg  <= sizes_reset();
            pad_before_reg    <= '0;
            pad_after_reg     <= '0;
            periodic_mask_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_NUM_DIMS:     num_dims_reg      <= cfg_data[ND_W-1:0];
                CFG_PADDED_SIZES: padded_sizes_reg  <= cfg_data;
                CFG_PAD_BEFORE:   pad_before_reg    <= cfg_data;
                CFG_PAD_AFTER:    pad_after_reg     <= cfg_data;
                CFG_PERIODIC:     periodic_mask_reg <= cfg_data[MASK_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective dimension count: zero acts as one, large values saturate.
    logic [NDC_W-1:0] nd_eff;
    assign nd_eff = (num_dims_reg == '0) ? NDC_W'(1) :
                    ((int'(num_dims_reg) > MAX_DIMS) ? NDC_W'(MAX_DIMS) :
                     NDC_W'(num_dims_reg));

    // Span check over every dimension in use.
    logic [MAX_DIMS-1:0] span_bad;
    for (genvar d = 0; d < MAX_DIMS; d++)
    begin : g_span
        logic signed [DIM_BITS+1:0] span;
        assign span = signed'({2'b00, field_of(padded_sizes_reg, JW'(d))})
                    - signed'({2'b00, field_of(pad_before_reg, JW'(d))})
                    - signed'({2'b00, field_of(pad_after_reg, JW'(d))});
        assign span_bad[d] = (int'(nd_eff) > d) && (span <= 0);
    end

    // Per-slot dimension parameters; slot 0 handles the fastest dimension.
    logic                act_s [MAX_DIMS];
    logic                per_s [MAX_DIMS];
    logic [DIM_BITS-1:0] sz_s  [MAX_DIMS];
    logic [DIM_BITS-1:0] pb_s  [MAX_DIMS];
    logic [DIM_BITS-1:0] sp_s  [MAX_DIMS];
    for (genvar s = 0; s < MAX_DIMS; s++)
    begin : g_slot
        logic [JW-1:0] j;
        logic          pbit;
        assign j = JW'(int'(nd_eff) - 1 - s);
        assign act_s[s] = int'(nd_eff) > s;
        assign sz_s[s]  = field_of(padded_sizes_reg, j);
        assign pb_s[s]  = field_of(pad_before_reg, j);
        assign sp_s[s]  = sz_s[s] - pb_s[s] - field_of(pad_after_reg, j);
        always_comb
        begin
            pbit = 1'b0;
            for (int k = 0; k < MASK_W; k++)
            begin
                if (int'(j) == k)
                begin
                    pbit = periodic_mask_reg[k];
                end
            end
        end
        assign per_s[s] = pbit;
    end

    logic  adv;
    logic  [NUM_STAGES:0] vld_reg;
    pipe_t pipe_reg  [NUM_STAGES+1];
    pipe_t pipe_next [NUM_STAGES+1];

    assign adv      = !(vld_reg[NUM_STAGES] && out_stall);
    assign in_stall = !adv;

    always_comb
    begin
        pipe_next[0]        = '0;
        pipe_next[0].q      = padded_index;
        pipe_next[0].stride = IDX_W'(1);
        pipe_next[0].err    = |span_bad;
    end

    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_stage
        localparam int S = g / SLOT_LEN;
        localparam int T = g % SLOT_LEN;
        always_comb
        begin
            pipe_t                     a;
            pipe_t                     b;
            logic [DIM_BITS:0]         rs;
            logic signed [DIM_BITS:0]  diff;
            logic [DIM_BITS-1:0]       spm1;
            logic [IDX_W+DIM_BITS-1:0] prod;
            logic [IDX_W+DIM_BITS-1:0] sprod;
            a     = pipe_reg[g];
            b     = a;
            rs    = '0;
            diff  = '0;
            spm1  = sp_s[S] - DIM_BITS'(1);
            prod  = '0;
            sprod = '0;
            if (act_s[S])
            begin
                if (T < T_POS)
                begin
                    // One bit of the index division by the padded size.
                    rs = {((T == 0) ? {DIM_BITS{1'b0}} : a.r), a.q[IDX_W-1]};
                    if (rs >= {1'b0, sz_s[S]})
                    begin
                        b.r = DIM_BITS'(rs - {1'b0, sz_s[S]});
                        b.q = {a.q[IDX_W-2:0], 1'b1};
                    end
                    else
                    begin
                        b.r = rs[DIM_BITS-1:0];
                        b.q = {a.q[IDX_W-2:0], 1'b0};
                    end
                end
                else if (T == T_POS)
                begin
                    diff  = signed'({1'b0, a.r}) - signed'({1'b0, pb_s[S]});
                    b.neg = diff[DIM_BITS];
                    b.m   = diff[DIM_BITS] ? DIM_BITS'(-diff) : diff[DIM_BITS-1:0];
                    b.wr  = '0;
                    if (diff[DIM_BITS])
                    begin
                        b.c = '0;
                    end
                    else if (diff[DIM_BITS-1:0] > spm1)
                    begin
                        b.c = spm1;
                    end
                    else
                    begin
                        b.c = diff[DIM_BITS-1:0];
                    end
                end
                else if (T < T_FIX)
                begin
                    // One bit of the magnitude remainder by the span.
                    rs = {a.wr, a.m[DIM_BITS-1]};
                    b.m = a.m << 1;
                    if (rs >= {1'b0, sp_s[S]})
                    begin
                        b.wr = DIM_BITS'(rs - {1'b0, sp_s[S]});
                    end
                    else
                    begin
                        b.wr = rs[DIM_BITS-1:0];
                    end
                end
                else if (T == T_FIX)
                begin
                    if (per_s[S])
                    begin
                        if (!a.neg || a.wr == '0)
                        begin
                            b.c = a.wr;
                        end
                        else
                        begin
                            b.c = sp_s[S] - a.wr;
                        end
                    end
                end
                else if (T == T_MUL)
                begin
                    prod     = (IDX_W+DIM_BITS)'(a.stride) * (IDX_W+DIM_BITS)'(a.c);
                    sprod    = (IDX_W+DIM_BITS)'(a.stride) * (IDX_W+DIM_BITS)'(sp_s[S]);
                    b.p      = prod[IDX_W-1:0];
                    b.stride = sprod[IDX_W-1:0];
                end
                else
                begin
                    b.flat = a.flat + a.p;
                end
            end
            pipe_next[g+1] = b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int g = 0; g <= NUM_STAGES; g++)
            begin
                pipe_reg[g] <= pipe_next[g];
            end
        end
    end

    // A quotient left over after every dimension means the index is past the end.
    logic fin_err;
    assign fin_err      = pipe_reg[NUM_STAGES].err || (pipe_reg[NUM_STAGES].q != '0);
    assign out_valid    = vld_reg[NUM_STAGES];
    assign index_error  = fin_err;
    assign source_index = fin_err ? '0 : pipe_reg[NUM_STAGES].flat;

endmodule
`default_nettype wire

// ===== hdl/ptsi_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptsi_checker
// Port-level checks of the padded tensor source index unit, bound to the top.
// ----------------------------------------------------------------------------
module ptsi_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       cfg_valid,
    input wire logic                       cfg_ready,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [ptsi_pkg::IDX_W-1:0] source_index,
    input wire logic                       index_error
);
    import ptsi_pkg::*;

    // A stalled result holds until its transfer.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(source_index))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_error |-> source_index == '0)
        else $error("error result with nonzero index");

    // The input side stalls only when a finished result is held up.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind padded_tensor_source_index_unit ptsi_checker u_ptsi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .source_index (source_index),
    .index_error  (index_error)
);
`default_nettype wire

// ===== test/tb_padded_tensor_source_index_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_padded_tensor_source_index_unit
// Checks the padded tensor source index unit against an in-bench prediction
// of the wrap or clamp index map, over several register settings, with random
// idling on both channels.
// ----------------------------------------------------------------------------
module tb_padded_tensor_source_index_unit;
    import ptsi_pkg::*;

    localparam int LATENCY    = 209;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [IDX_W-1:0] src;
        logic             err;
    } mapped_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [IDX_W-1:0]     padded_index;
    logic                 out_valid;
    logic                 out_stall;
    logic [IDX_W-1:0]     source_index;
    logic                 index_error;

    // Shadow copy of the block's registers.
    logic [ND_W-1:0]   m_num_dims;
    logic [CFG_W-1:0]  m_sizes;
    logic [CFG_W-1:0]  m_before;
    logic [CFG_W-1:0]  m_after;
    logic [MASK_W-1:0] m_mask;

    logic [IDX_W-1:0] index_queue[$];
    mapped_t          expected_map[$];
    int               mismatches = 0;
    int               cycle_count = 0;
    int               in_idle;
    int               out_idle;
    bit               calm;

    padded_tensor_source_index_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .padded_index(padded_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .source_index(source_index), .index_error(index_error)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint dim_field(logic [CFG_W-1:0] r, int j);
        return longint'(r[DIM_BITS*j +: DIM_BITS]);
    endfunction

    function automatic mapped_t map_index(logic [IDX_W-1:0] idx);
        mapped_t     res;
        int          nd;
        longint      span[MAX_DIMS];
        longint      sz;
        longint      pos;
        longint      c;
        logic [63:0] total;
        logic [63:0] rem;
        logic [63:0] stride;
        logic [63:0] flat;
        bit          bad;
        nd = int'(m_num_dims);
        if (nd < 1) nd = 1;
        if (nd > MAX_DIMS) nd = MAX_DIMS;
        bad = 0;
        total = 1;
        for (int j = 0; j < nd; j++) begin
            span[j] = dim_field(m_sizes, j) - dim_field(m_before, j) - dim_field(m_after, j);
            if (span[j] <= 0) bad = 1;
            total = total * 64'(dim_field(m_sizes, j));
            if (total > (64'd1 << 40)) total = 64'd1 << 40;
        end
        if (!bad && 64'(idx) >= total) bad = 1;
        if (bad) begin
            res.src = '0;
            res.err = 1'b1;
            return res;
        end
        rem = 64'(idx);
        stride = 1;
        flat = 0;
        for (int j = nd - 1; j >= 0; j--) begin
            sz = dim_field(m_sizes, j);
            pos = longint'(rem % 64'(sz)) - dim_field(m_before, j);
            if (m_mask[j]) begin
                c = pos % span[j];
                if (c < 0) c += span[j];
            end else begin
                c = (pos < 0) ? 0 : pos;
                if (c > span[j] - 1) c = span[j] - 1;
            end
            flat = flat + stride * 64'(c);
            stride = stride * 64'(span[j]);
            rem = rem / 64'(sz);
        end
        res.src = flat[IDX_W-1:0];
        res.err = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [IDX_W-1:0] got, logic [IDX_W-1:0] want);
        $display("MISMATCH @%0t %s: got 0x%08h expected 0x%08h", $time, what, got, want);
        mismatches++;
    endtask

    // Driver: in_valid stays high across back-to-back transfers.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid     <= 1'b0;
            padded_index <= '0;
            in_idle      <= 0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) void'(index_queue.pop_front());
            if (in_idle > 0) begin
                in_idle  <= in_idle - 1;
                in_valid <= 1'b0;
            end else if (index_queue.size() > 0) begin
                padded_index <= index_queue[0];
                in_valid     <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) in_idle <= $urandom_range(1, 6);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // The expectation is computed at acceptance, with the registers in force then.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) expected_map.push_back(map_index(padded_index));
    end

    // Monitor and receiver stall.
    always @(posedge clk or negedge rst_n) begin
        mapped_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_idle  <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_map.size() == 0) begin
                    report_mismatch("unexpected transfer", source_index, '0);
                end else begin
                    want = expected_map.pop_front();
                    if (source_index !== want.src)
                        report_mismatch("source_index", source_index, want.src);
                    if (index_error !== want.err)
                        report_mismatch("index_error", 32'(index_error), 32'(want.err));
                end
            end
            if (out_idle > 0) begin
                out_idle  <= out_idle - 1;
                out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                out_idle  <= $urandom_range(0, 5);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** padded_tensor_source_index_unit: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t which, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (which)
            CFG_NUM_DIMS:     m_num_dims = value[ND_W-1:0];
            CFG_PADDED_SIZES: m_sizes    = value;
            CFG_PAD_BEFORE:   m_before   = value;
            CFG_PAD_AFTER:    m_after    = value;
            CFG_PERIODIC:     m_mask     = value[MASK_W-1:0];
            default:          ;
        endcase
    endtask

    // Waits until every queued item has been sent and every result received.
    task automatic drain();
        while (index_queue.size() > 0 || in_valid || expected_map.size() > 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic load_shape(int nd, logic [63:0] sz, logic [63:0] pb, logic [63:0] pa,
                              logic [3:0] pm);
        write_reg(CFG_NUM_DIMS, 64'(nd));
        write_reg(CFG_PADDED_SIZES, sz);
        write_reg(CFG_PAD_BEFORE, pb);
        write_reg(CFG_PAD_AFTER, pa);
        write_reg(CFG_PERIODIC, 64'(pm));
    endtask

    // Random shape with small dims, so that most indices fall inside the tensor.
    task automatic random_phase(int count);
        logic [63:0] sz, pb, pa;
        int          nd;
        longint      total;
        nd = $urandom_range(0, 7);
        sz = '0; pb = '0; pa = '0;
        total = 1;
        for (int j = 0; j < MAX_DIMS; j++) begin
            sz[16*j +: 16] = $urandom_range(1, 12);
            pb[16*j +: 16] = $urandom_range(0, 7);
            pa[16*j +: 16] = $urandom_range(0, 3);
            if ($urandom_range(0, 7) != 0 &&
                sz[16*j +: 16] <= pb[16*j +: 16] + pa[16*j +: 16])
                sz[16*j +: 16] = pb[16*j +: 16] + pa[16*j +: 16] + $urandom_range(1, 4);
            if (j < ((nd < 1) ? 1 : (nd > 4 ? 4 : nd))) total *= sz[16*j +: 16];
        end
        load_shape(nd, sz, pb, pa, 4'($urandom));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) index_queue.push_back($urandom);
            else index_queue.push_back(32'($urandom_range(0, int'(total))));
        end
        drain();
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_NUM_DIMS;
        cfg_data = '0;
        calm = 0;
        m_num_dims = 3'd1;
        m_sizes = sizes_reset();
        m_before = '0;
        m_after = '0;
        m_mask = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset shape: only index 0 is inside.
        index_queue.push_back(32'd0);
        index_queue.push_back(32'd1);
        index_queue.push_back(32'hFFFF_FFFF);
        drain();

        // Large leading pad on a periodic dim, and clamping on the others.
        load_shape(3, 64'h0000_0009_0007_000A, 64'h0000_0002_0000_0009,
                   64'h0000_0001_0003_0000, 4'b0001);
        for (int i = 0; i < 12; i++) index_queue.push_back(32'($urandom_range(0, 629)));
        index_queue.push_back(32'd629);
        index_queue.push_back(32'd630);
        drain();

        // Zero size, negative span, and a dimension count above the maximum.
        load_shape(7, 64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_0000_0000_0000,
                   64'hFFFF_0000_0000_0000, 4'b1111);
        index_queue.push_back(32'd0);
        drain();
        write_reg(CFG_PADDED_SIZES, 64'hFFFF_FFFF_FFFF_FFFF);
        index_queue.push_back(32'd5);
        drain();
        // Full-width sizes, flat index wraps modulo 2^32.
        load_shape(0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0, 4'b0000);
        index_queue.push_back(32'hFFFF_FFFE);
        index_queue.push_back(32'h0000_FFFF);
        drain();
        write_reg(CFG_NUM_DIMS, 64'd4);
        index_queue.push_back(32'hFFFF_FFFF);
        index_queue.push_back(32'h8000_0000);
        drain();
        write_reg(CFG_PAD_BEFORE, 64'hFFFE_FFFE_FFFE_FFFE);
        write_reg(CFG_PERIODIC, 64'hF);
        index_queue.push_back(32'h1234_5678);
        drain();

        for (int p = 0; p < 10; p++) random_phase(60);
        calm = 1;
        random_phase(40);

        if (mismatches == 0)
            $display("** padded_tensor_source_index_unit: PASSED **");
        else
            $display("** padded_tensor_source_index_unit: FAILED **");
        $finish;
    end
endmodule
